// ===== hw/rtl/qte_pkg.sv =====
package qte_pkg;

    localparam int QW           = 16;
    localparam int PW           = 34;
    localparam int SW           = 30;
    localparam int VW           = 57;
    localparam int RW           = 29;
    localparam int CW           = 38;
    localparam int ZW           = 34;
    localparam int MW           = 32;
    localparam int AW           = 15;
    localparam int PAW          = 14;
    localparam int LANES        = 3;
    localparam int CORDIC_STEPS = 24;
    localparam int SQ_STEPS     = 29;

    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    localparam logic signed [PW-1:0] ONE_Q28     = PW'(64'sd268435456);
    localparam logic [VW-1:0]        ONE_Q56     = VW'(1) << 56;
    localparam logic signed [ZW-1:0] HALF_TURN   = ZW'(64'sd2147483648);
    localparam logic [MW-1:0]        PI_Q30      = 32'd3373259426;
    localparam logic [AW-1:0]        LIM_PI      = AW'(12868);
    localparam logic [AW-1:0]        LIM_HALF_PI = AW'(6434);

    typedef struct packed {
        logic signed [PW-1:0] yn;
        logic signed [PW-1:0] yd;
        logic signed [PW-1:0] rn;
        logic signed [PW-1:0] rd;
        logic signed [SW-1:0] s;
    } t_args;

    typedef struct packed {
        t_args         a;
        logic [VW-1:0] v;
    } t_front;

    typedef struct packed {
        t_args         a;
        logic [RW-1:0] c;
    } t_cord_in;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = ZW'(536870912);
            5'd1:    r = ZW'(316933406);
            5'd2:    r = ZW'(167458907);
            5'd3:    r = ZW'(85004756);
            5'd4:    r = ZW'(42667331);
            5'd5:    r = ZW'(21354465);
            5'd6:    r = ZW'(10679838);
            5'd7:    r = ZW'(5340245);
            5'd8:    r = ZW'(2670163);
            5'd9:    r = ZW'(1335087);
            5'd10:   r = ZW'(667544);
            5'd11:   r = ZW'(333772);
            5'd12:   r = ZW'(166886);
            5'd13:   r = ZW'(83443);
            5'd14:   r = ZW'(41722);
            5'd15:   r = ZW'(20861);
            5'd16:   r = ZW'(10430);
            5'd17:   r = ZW'(5215);
            5'd18:   r = ZW'(2608);
            5'd19:   r = ZW'(1304);
            5'd20:   r = ZW'(652);
            5'd21:   r = ZW'(326);
            5'd22:   r = ZW'(163);
            5'd23:   r = ZW'(81);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/qte_front.sv =====
module qte_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [4*qte_pkg::QW-1:0]    i_data,
    output logic                        o_valid,
    output qte_pkg::t_front             o_data
);

    logic signed [qte_pkg::QW-1:0] w, x, y, z;
    assign w = $signed(i_data[qte_pkg::QW-1:0]);
    assign x = $signed(i_data[2*qte_pkg::QW-1:qte_pkg::QW]);
    assign y = $signed(i_data[3*qte_pkg::QW-1:2*qte_pkg::QW]);
    assign z = $signed(i_data[4*qte_pkg::QW-1:3*qte_pkg::QW]);

    // stage 1: component products
    logic                            r_v1;
    logic signed [2*qte_pkg::QW-1:0] r_xy, r_wz, r_ww, r_xx, r_yy, r_zz, r_wy, r_xz, r_yz, r_wx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_xy <= x * y;
            r_wz <= w * z;
            r_ww <= w * w;
            r_xx <= x * x;
            r_yy <= y * y;
            r_zz <= z * z;
            r_wy <= w * y;
            r_xz <= x * z;
            r_yz <= y * z;
            r_wx <= w * x;
        end
    end

    // stage 2: sums and pitch argument saturation
    logic                         r_v2;
    qte_pkg::t_args               r_a2;
    qte_pkg::t_args               n_a2;
    logic signed [qte_pkg::PW-1:0] s_raw;

    always_comb begin
        n_a2.yn = (qte_pkg::PW'(r_xy) + qte_pkg::PW'(r_wz)) <<< 1;
        n_a2.yd = qte_pkg::PW'(r_ww) + qte_pkg::PW'(r_xx)
                - qte_pkg::PW'(r_yy) - qte_pkg::PW'(r_zz);
        n_a2.rn = (qte_pkg::PW'(r_yz) + qte_pkg::PW'(r_wx)) <<< 1;
        n_a2.rd = qte_pkg::ONE_Q28 - (qte_pkg::PW'(r_xx) <<< 1) - (qte_pkg::PW'(r_yy) <<< 1);
        s_raw   = (qte_pkg::PW'(r_wy) - qte_pkg::PW'(r_xz)) <<< 1;
        if (s_raw > qte_pkg::ONE_Q28) begin
            n_a2.s = qte_pkg::SW'(qte_pkg::ONE_Q28);
        end else if (s_raw < -qte_pkg::ONE_Q28) begin
            n_a2.s = qte_pkg::SW'(-qte_pkg::ONE_Q28);
        end else begin
            n_a2.s = qte_pkg::SW'(s_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_a2 <= n_a2;
        end
    end

    // stage 3: square of the pitch argument
    logic                            r_v3;
    qte_pkg::t_args                  r_a3;
    logic [qte_pkg::VW-1:0]          r_ss;
    logic signed [2*qte_pkg::SW-1:0] sq;

    assign sq = r_a2.s * r_a2.s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_a3 <= r_a2;
            r_ss <= qte_pkg::VW'(sq);
        end
    end

    // stage 4: radicand for the cosine
    logic            r_v4;
    qte_pkg::t_front r_d4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_d4.a <= r_a3;
            r_d4.v <= qte_pkg::ONE_Q56 - r_ss;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_d4;

endmodule

// ===== hw/rtl/qte_isqrt.sv =====
module qte_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  qte_pkg::t_front   i_data,
    output logic              o_valid,
    output qte_pkg::t_cord_in o_data
);

    localparam int N = qte_pkg::SQ_STEPS;

    logic                   r_valid [N];
    qte_pkg::t_args         r_args  [N];
    logic [qte_pkg::VW-1:0] r_rem   [N];
    logic [qte_pkg::VW-1:0] r_res   [N];

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam logic [qte_pkg::VW-1:0] BIT = qte_pkg::VW'(1) << (2 * (N - 1 - g));

        logic                   p_valid;
        qte_pkg::t_args         p_args;
        logic [qte_pkg::VW-1:0] p_rem, p_res, trial, n_rem, n_res;

        if (g == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_args  = i_data.a;
            assign p_rem   = i_data.v;
            assign p_res   = '0;
        end else begin : g_next
            assign p_valid = r_valid[g-1];
            assign p_args  = r_args[g-1];
            assign p_rem   = r_rem[g-1];
            assign p_res   = r_res[g-1];
        end

        always_comb begin
            trial = p_res + BIT;
            if (p_rem >= trial) begin
                n_rem = p_rem - trial;
                n_res = (p_res >> 1) + BIT;
            end else begin
                n_rem = p_rem;
                n_res = p_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= p_valid;
            end
            if (i_en) begin
                r_args[g] <= p_args;
                r_rem[g]  <= n_rem;
                r_res[g]  <= n_res;
            end
        end
    end

    assign o_valid  = r_valid[N-1];
    assign o_data.a = r_args[N-1];
    assign o_data.c = r_res[N-1][qte_pkg::RW-1:0];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
module qte_cordic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [qte_pkg::CW-1:0] i_x [qte_pkg::LANES],
    input  logic signed [qte_pkg::CW-1:0] i_y [qte_pkg::LANES],
    output logic                          o_valid,
    output logic signed [qte_pkg::ZW-1:0] o_z [qte_pkg::LANES]
);

    localparam int N = qte_pkg::CORDIC_STEPS;
    localparam int L = qte_pkg::LANES;

    logic                          r_valid [N+1];
    logic signed [qte_pkg::CW-1:0] r_x     [N+1][L];
    logic signed [qte_pkg::CW-1:0] r_y     [N+1][L];
    logic signed [qte_pkg::ZW-1:0] r_z     [N+1][L];
    logic                          r_zero  [N+1][L];

    // quadrant fold: left half plane turned by a half turn
    logic signed [qte_pkg::CW-1:0] n_x0 [L];
    logic signed [qte_pkg::CW-1:0] n_y0 [L];
    logic signed [qte_pkg::ZW-1:0] n_z0 [L];
    logic                          n_zero0 [L];

    always_comb begin
        for (int l = 0; l < L; l++) begin
            n_zero0[l] = (i_x[l] == '0) && (i_y[l] == '0);
            if (i_x[l] < 0) begin
                n_x0[l] = -i_x[l];
                n_y0[l] = -i_y[l];
                n_z0[l] = (i_y[l] >= 0) ? qte_pkg::HALF_TURN : -qte_pkg::HALF_TURN;
            end else begin
                n_x0[l] = i_x[l];
                n_y0[l] = i_y[l];
                n_z0[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            for (int l = 0; l < L; l++) begin
                r_x[0][l]    <= n_x0[l];
                r_y[0][l]    <= n_y0[l];
                r_z[0][l]    <= n_z0[l];
                r_zero[0][l] <= n_zero0[l];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_iter
        localparam logic signed [qte_pkg::ZW-1:0] ATAN = qte_pkg::atan_entry(5'(g));

        logic signed [qte_pkg::CW-1:0] n_x [L];
        logic signed [qte_pkg::CW-1:0] n_y [L];
        logic signed [qte_pkg::ZW-1:0] n_z [L];

        always_comb begin
            for (int l = 0; l < L; l++) begin
                if (r_y[g][l] >= 0) begin
                    n_x[l] = r_x[g][l] + (r_y[g][l] >>> g);
                    n_y[l] = r_y[g][l] - (r_x[g][l] >>> g);
                    n_z[l] = r_z[g][l] + ATAN;
                end else begin
                    n_x[l] = r_x[g][l] - (r_y[g][l] >>> g);
                    n_y[l] = r_y[g][l] + (r_x[g][l] >>> g);
                    n_z[l] = r_z[g][l] - ATAN;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
            if (i_en) begin
                for (int l = 0; l < L; l++) begin
                    r_x[g+1][l]    <= n_x[l];
                    r_y[g+1][l]    <= n_y[l];
                    r_z[g+1][l]    <= n_z[l];
                    r_zero[g+1][l] <= r_zero[g][l];
                end
            end
        end
    end

    assign o_valid = r_valid[N];

    always_comb begin
        for (int l = 0; l < L; l++) begin
            o_z[l] = r_zero[N][l] ? '0 : r_z[N][l];
        end
    end

endmodule

// ===== hw/rtl/qte_scale.sv =====
module qte_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [qte_pkg::ZW-1:0] i_z [qte_pkg::LANES],
    output logic                          o_valid,
    output logic signed [qte_pkg::AW-1:0] o_ang [qte_pkg::LANES]
);

    localparam int L = qte_pkg::LANES;

    // stage 1: clamp to a half turn, split sign and magnitude
    logic                   r_v1;
    logic [qte_pkg::MW-1:0] r_mag [L];
    logic                   r_neg1 [L];
    logic [qte_pkg::MW-1:0] n_mag [L];
    logic signed [qte_pkg::ZW-1:0] zc [L];

    always_comb begin
        for (int l = 0; l < L; l++) begin
            if (i_z[l] > qte_pkg::HALF_TURN) begin
                zc[l] = qte_pkg::HALF_TURN;
            end else if (i_z[l] < -qte_pkg::HALF_TURN) begin
                zc[l] = -qte_pkg::HALF_TURN;
            end else begin
                zc[l] = i_z[l];
            end
            n_mag[l] = (zc[l] < 0) ? qte_pkg::MW'(-zc[l]) : qte_pkg::MW'(zc[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            for (int l = 0; l < L; l++) begin
                r_mag[l]  <= n_mag[l];
                r_neg1[l] <= i_z[l] < 0;
            end
        end
    end

    // stage 2: binary angle to radians
    logic                     r_v2;
    logic [2*qte_pkg::MW-1:0] r_prod [L];
    logic                     r_neg2 [L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            for (int l = 0; l < L; l++) begin
                r_prod[l] <= r_mag[l] * qte_pkg::PI_Q30;
                r_neg2[l] <= r_neg1[l];
            end
        end
    end

    // stage 3: round, limit, restore sign
    logic                          r_v3;
    logic signed [qte_pkg::AW-1:0] r_ang [L];
    logic signed [qte_pkg::AW-1:0] n_ang [L];
    logic [2*qte_pkg::MW-1:0]      rnd [L];
    logic [qte_pkg::AW-1:0]        q [L];
    logic [qte_pkg::AW-1:0]        lim [L];

    always_comb begin
        for (int l = 0; l < L; l++) begin
            lim[l] = (l == qte_pkg::LANE_PITCH) ? qte_pkg::LIM_HALF_PI : qte_pkg::LIM_PI;
            rnd[l] = r_prod[l] + ((2*qte_pkg::MW)'(1) << 48);
            q[l]   = rnd[l][49 +: qte_pkg::AW];
            if (q[l] > lim[l]) begin
                q[l] = lim[l];
            end
            n_ang[l] = r_neg2[l] ? -$signed(q[l]) : $signed(q[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            for (int l = 0; l < L; l++) begin
                r_ang[l] <= n_ang[l];
            end
        end
    end

    assign o_valid = r_v3;

    always_comb begin
        for (int l = 0; l < L; l++) begin
            o_ang[l] = r_ang[l];
        end
    end

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Quaternion (w, x, y, z, signed Q1.14) to ZYX Euler angles (yaw, pitch, roll in
// radians, signed Q2.12). Fully pipelined: one word in and one word out per clock
// while the output is not held (4 product/sum stages, 29 square-root stages for the
// pitch cosine, 25 CORDIC vectoring stages with three parallel lanes, 3 scaling
// stages). The whole pipeline advances whenever its output register is empty or
// being taken; when the output is held, the pipeline and the input stall together.
module quaternion_to_euler_angles (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // yaw_angle, pitch_angle, roll_angle, zero pad
);

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic              f_valid;
    qte_pkg::t_front   f_data;
    logic              s_valid;
    qte_pkg::t_cord_in s_data;
    logic              c_valid;
    logic signed [qte_pkg::CW-1:0] c_x [qte_pkg::LANES];
    logic signed [qte_pkg::CW-1:0] c_y [qte_pkg::LANES];
    logic signed [qte_pkg::ZW-1:0] c_z [qte_pkg::LANES];
    logic signed [qte_pkg::AW-1:0] ang [qte_pkg::LANES];

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_valid (f_valid),
        .o_data  (f_data)
    );

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_data  (f_data),
        .o_valid (s_valid),
        .o_data  (s_data)
    );

    assign c_x[qte_pkg::LANE_YAW]   = qte_pkg::CW'(s_data.a.yd);
    assign c_y[qte_pkg::LANE_YAW]   = qte_pkg::CW'(s_data.a.yn);
    assign c_x[qte_pkg::LANE_PITCH] = $signed(qte_pkg::CW'(s_data.c));
    assign c_y[qte_pkg::LANE_PITCH] = qte_pkg::CW'(s_data.a.s);
    assign c_x[qte_pkg::LANE_ROLL]  = qte_pkg::CW'(s_data.a.rd);
    assign c_y[qte_pkg::LANE_ROLL]  = qte_pkg::CW'(s_data.a.rn);

    qte_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_x     (c_x),
        .i_y     (c_y),
        .o_valid (c_valid),
        .o_z     (c_z)
    );

    qte_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (c_valid),
        .i_z     (c_z),
        .o_valid (o_m_axis_tvalid),
        .o_ang   (ang)
    );

    assign o_m_axis_tdata = {4'b0,
                             ang[qte_pkg::LANE_ROLL],
                             ang[qte_pkg::LANE_PITCH][qte_pkg::PAW-1:0],
                             ang[qte_pkg::LANE_YAW]};

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [14:0] roll;
        logic signed [13:0] pitch;
        logic signed [14:0] yaw;
    } t_euler;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 100;
    localparam int          REPORT_MAX     = 30;
    localparam longint      HALF_TURN_BAU  = 64'sd2147483648;
    localparam longint      ONE_Q28        = 64'sd268435456;
    localparam longint unsigned PI_Q30     = 64'd3373259426;
    localparam longint      LIM_PI         = 12868;
    localparam longint      LIM_HALF_PI    = 6434;
    localparam longint      ATAN_BAU [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_data = '0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;

    t_euler      angles_due[$];
    int          snd_idle = 0;
    int          rcv_stall = 0;
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          saturated_pitch = 0;
    int          quiet_cycles = 0;

    quaternion_to_euler_angles i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),   // quat_w, quat_x, quat_y, quat_z
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)  // yaw, pitch, roll, zero pad
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint vector_angle(longint yv, longint xv);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        if (xv == 0 && yv == 0) begin
            return 0;
        end
        if (xv < 0) begin
            ang = (yv >= 0) ? HALF_TURN_BAU : -HALF_TURN_BAU;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < 24; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                ang += ATAN_BAU[i];
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                ang -= ATAN_BAU[i];
            end
        end
        if (ang > HALF_TURN_BAU) ang = HALF_TURN_BAU;
        if (ang < -HALF_TURN_BAU) ang = -HALF_TURN_BAU;
        return ang;
    endfunction

    function automatic longint bau_to_rad(longint ang, longint lim);
        longint unsigned mag;
        longint unsigned r;
        mag = (ang < 0) ? longint'(-ang) : longint'(ang);
        r = (mag * PI_Q30 + (64'd1 << 48)) >> 49;
        if (r > longint'(lim)) r = lim;
        return (ang < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic t_euler predict_euler(logic [63:0] d);
        longint w, x, y, z, s;
        longint unsigned c;
        t_euler e;
        w = longint'($signed(d[15:0]));
        x = longint'($signed(d[31:16]));
        y = longint'($signed(d[47:32]));
        z = longint'($signed(d[63:48]));
        e.yaw = 15'(bau_to_rad(vector_angle(2 * (x * y + w * z),
                                            w * w + x * x - y * y - z * z), LIM_PI));
        s = 2 * (w * y - x * z);
        if (s > ONE_Q28) s = ONE_Q28;
        if (s < -ONE_Q28) s = -ONE_Q28;
        c = root_floor(longint'(ONE_Q28 * ONE_Q28) - longint'(s * s));
        e.pitch = 14'(bau_to_rad(vector_angle(s, longint'(c)), LIM_HALF_PI));
        e.roll = 15'(bau_to_rad(vector_angle(2 * (y * z + w * x),
                                             ONE_Q28 - 2 * x * x - 2 * y * y), LIM_PI));
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= REPORT_MAX)
            $display("tb: %s mismatch at word %0d: got %0d, want %0d",
                     what, words_out, got, want);
    endtask

    task automatic send_quat(int w, int x, int y, int z);
        logic [63:0] d;
        d = {16'(z), 16'(y), 16'(x), 16'(w)};
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        angles_due.push_back(predict_euler(d));
        words_in++;
        if (2 * ((w * y) - (x * z)) > 268435456 || 2 * ((w * y) - (x * z)) < -268435456)
            saturated_pitch++;
    endtask

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge i_clk) begin
        t_euler got;
        t_euler want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = o_m_axis_tdata[43:0];
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = angles_due.pop_front();
                if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
                if (got.pitch !== want.pitch)
                    report_mismatch("pitch", got.pitch, want.pitch);
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (o_m_axis_tdata[47:44] !== 4'd0)
                    report_mismatch("pad", o_m_axis_tdata[47:44], 0);
            end
            words_out++;
        end
        if ((o_m_axis_tvalid && m_ready) || (s_valid && o_s_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired, %0d words outstanding", angles_due.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        int v;
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, -16384, 0, 0);
        send_quat(0, 0, -16384, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(-16384, 16384, -16384, 16384);
        // pitch at and beyond the poles
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 16384, -16384, 16384);
        // vector on the negative x axis, numerator sign both ways
        send_quat(0, 0, 0, 11585);
        send_quat(11585, 0, 0, 11585);
        send_quat(0, 16384, 0, 1);
        send_quat(0, 16384, 0, -1);
        send_quat(16383, 16383, 1, -1);
        send_quat(1, -1, 16383, -16383);
        v = 8192;
        send_quat(v, v, v, v);
        send_quat(v, -v, v, -v);
    endtask

    task automatic test_random(int n, int snd_pct, int rcv_pct);
        real a, b, c, d, nrm;
        int w, x, y, z, mode;
        snd_idle = snd_pct;
        rcv_stall = rcv_pct;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(99);
            if (mode < 60) begin
                // unit quaternion with random direction
                a = real'($urandom_range(2000)) - 1000.0;
                b = real'($urandom_range(2000)) - 1000.0;
                c = real'($urandom_range(2000)) - 1000.0;
                d = real'($urandom_range(2000)) - 1000.0;
                nrm = $sqrt(a * a + b * b + c * c + d * d);
                if (nrm < 1.0) nrm = 1.0;
                w = $rtoi(a * 16384.0 / nrm);
                x = $rtoi(b * 16384.0 / nrm);
                y = $rtoi(c * 16384.0 / nrm);
                z = $rtoi(d * 16384.0 / nrm);
            end else if (mode < 75) begin
                w = int'($urandom_range(32768)) - 16384;
                x = int'($urandom_range(32768)) - 16384;
                y = int'($urandom_range(32768)) - 16384;
                z = int'($urandom_range(32768)) - 16384;
            end else if (mode < 88) begin
                // near gimbal lock
                w = 11585 + int'($urandom_range(200)) - 100;
                y = $urandom_range(1) ? w : -w;
                x = int'($urandom_range(200)) - 100;
                z = $urandom_range(1) ? x : -x;
            end else begin
                w = int'($urandom_range(64)) - 32;
                x = int'($urandom_range(64)) - 32;
                y = int'($urandom_range(64)) - 32;
                z = int'($urandom_range(64)) - 32;
            end
            send_quat(w, x, y, z);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle = 18;
        rcv_stall = 63;
        test_directed();
        test_random(320, 18, 63);
        test_random(330, 63, 18);
        test_random(330, 0, 0);
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d quaternions in, %0d angle words out", words_in, words_out);
        $display("tb: %0d had a saturated pitch argument", saturated_pitch);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
